// File: hw/rtl/bit_trie_max_xor_macros.svh
// Assertion macros shared by the trie controller and datapath.
`ifndef BIT_TRIE_MAX_XOR_MACROS_SVH
`define BIT_TRIE_MAX_XOR_MACROS_SVH

// Condition checked at every clock edge outside reset.
`define BTMX_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition checked in the cycle after a trigger, outside reset.
`define BTMX_ASSERT_NEXT(name, trig, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// File: hw/rtl/btmx_pkg.sv
// Shared constants, payload types and control structs of the bit trie max xor block.
package btmx_pkg;

  // Trie geometry
  localparam int VALUE_BITS = 32;
  localparam int NODE_COUNT = 4096;
  localparam int PTR_W      = $clog2(NODE_COUNT);
  localparam int CNT_W      = PTR_W + 1;
  localparam int LVL_W      = $clog2(VALUE_BITS);
  localparam logic [31:0] VALUE_MASK =
    (VALUE_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << VALUE_BITS) - 64'd1);

  // Function codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_QUERY  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [31:0] max_xor;
    logic [31:0] partner;
    logic [1:0]  status;
  } res_t;

  // One trie node: child pointers, zero means null
  typedef struct packed {
    logic [PTR_W-1:0] right;
    logic [PTR_W-1:0] left;
  } node_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic clear;
    logic ins_step;
    logic alloc_step;
    logic qry_step;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;
    logic lvl_zero;
    logic pool_ok;
    logic q_end;
    logic out_free;
  } dp_stat_t;

endpackage

// File: hw/rtl/btmx_datapath.sv
// Trie datapath: node memory, root and allocation registers, walk logic, result register.
`include "bit_trie_max_xor_macros.svh"

module btmx_datapath (
  input  logic               clk,
  input  logic               rst,
  input  btmx_pkg::cmd_t     item,
  input  btmx_pkg::dp_cmd_t  ctl,
  output btmx_pkg::dp_stat_t stat,
  output logic               res_valid,
  input  logic               res_ready,
  output btmx_pkg::res_t     res
);

  // Node memory; entry 0 is never used, the root lives in flip-flops
  btmx_pkg::node_t mem [btmx_pkg::NODE_COUNT];
  btmx_pkg::node_t rd_data;
  btmx_pkg::node_t root;

  logic [btmx_pkg::CNT_W-1:0] nf;
  logic [1:0]                 func_q;
  logic [31:0]                value_q;
  logic [btmx_pkg::LVL_W-1:0] level;
  logic [btmx_pkg::PTR_W-1:0] cur;
  logic [31:0]                partner;
  logic [1:0]                 status_q;

  btmx_pkg::node_t            kids;
  btmx_pkg::node_t            parent_upd;
  btmx_pkg::node_t            fresh;
  btmx_pkg::node_t            mem_wd;
  logic                       bit_b;
  logic [btmx_pkg::PTR_W-1:0] same;
  logic [btmx_pkg::PTR_W-1:0] want;
  logic [btmx_pkg::PTR_W-1:0] q_next;
  logic [btmx_pkg::PTR_W-1:0] rd_addr;
  logic [btmx_pkg::PTR_W-1:0] mem_wa;
  logic                       mem_we;
  logic                       lvl_zero;
  logic                       pool_ok;
  logic                       parent_wr;
  logic [btmx_pkg::LVL_W-1:0] lvl_m1;
  logic [btmx_pkg::CNT_W-1:0] free_cnt;
  logic [btmx_pkg::CNT_W-1:0] needed;
  logic [31:0]                low_mask;

  // Children of the current node: root registers or the last memory read
  always_comb begin
    kids     = (cur == '0) ? root : rd_data;
    bit_b    = value_q[level];
    same     = bit_b ? kids.right : kids.left;
    want     = bit_b ? kids.left : kids.right;
    q_next   = (want != '0) ? want : same;
    lvl_zero = (level == '0);
    lvl_m1   = level - btmx_pkg::LVL_W'(1);
    free_cnt = btmx_pkg::CNT_W'(btmx_pkg::NODE_COUNT) - nf;
    needed   = btmx_pkg::CNT_W'(level) + btmx_pkg::CNT_W'(1);
    pool_ok  = (free_cnt >= needed);
    low_mask = (32'd2 << level) - 32'd1;
    rd_addr  = ctl.qry_step ? q_next : same;
  end

  // Node writes: hook the new path onto its parent, then one new node a cycle
  always_comb begin
    parent_upd = kids;
    if (bit_b) begin
      parent_upd.right = nf[btmx_pkg::PTR_W-1:0];
    end else begin
      parent_upd.left = nf[btmx_pkg::PTR_W-1:0];
    end
    fresh = '0;
    if (!lvl_zero) begin
      if (value_q[lvl_m1]) begin
        fresh.right = nf[btmx_pkg::PTR_W-1:0] + btmx_pkg::PTR_W'(1);
      end else begin
        fresh.left = nf[btmx_pkg::PTR_W-1:0] + btmx_pkg::PTR_W'(1);
      end
    end
    parent_wr = ctl.ins_step && (same == '0) && pool_ok;
    mem_we    = ctl.alloc_step || (parent_wr && (cur != '0));
    mem_wa    = ctl.alloc_step ? nf[btmx_pkg::PTR_W-1:0] : cur;
    mem_wd    = ctl.alloc_step ? fresh : parent_upd;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[rd_addr];
  end

  // Root, allocation pointer and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      root      <= '0;
      nf        <= btmx_pkg::CNT_W'(1);
      res_valid <= 1'b0;
    end else begin
      if (ctl.clear) begin
        root <= '0;
        nf   <= btmx_pkg::CNT_W'(1);
      end
      if (parent_wr && (cur == '0)) begin
        root <= parent_upd;
      end
      if (ctl.alloc_step) begin
        nf <= nf + btmx_pkg::CNT_W'(1);
      end
      if (ctl.out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Walk registers and result payload
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      func_q   <= item.func;
      value_q  <= item.value & btmx_pkg::VALUE_MASK;
      level    <= btmx_pkg::LVL_W'(btmx_pkg::VALUE_BITS - 1);
      cur      <= '0;
      partner  <= '0;
      status_q <= btmx_pkg::STAT_OK;
    end
    if (ctl.ins_step) begin
      if (same != '0) begin
        cur   <= same;
        level <= lvl_m1;
      end else if (!pool_ok) begin
        status_q <= btmx_pkg::STAT_FULL;
      end
    end
    if (ctl.alloc_step) begin
      level <= lvl_m1;
    end
    if (ctl.qry_step) begin
      level <= lvl_m1;
      if (want != '0) begin
        partner[level] <= ~bit_b;
        cur            <= want;
      end else if (same != '0) begin
        partner[level] <= bit_b;
        cur            <= same;
      end else if (cur == '0) begin
        status_q <= btmx_pkg::STAT_EMPTY;
      end else begin
        partner <= partner | (value_q & low_mask);
      end
    end
    if (ctl.out_load) begin
      res.max_xor <= ((func_q == btmx_pkg::FUNC_QUERY) && (status_q == btmx_pkg::STAT_OK)) ?
                     (partner ^ value_q) : 32'd0;
      res.partner <= partner;
      res.status  <= status_q;
    end
  end

  always_comb begin
    stat.hit      = (same != '0);
    stat.lvl_zero = lvl_zero;
    stat.pool_ok  = pool_ok;
    stat.q_end    = lvl_zero || ((want == '0) && (same == '0));
    stat.out_free = !res_valid || res_ready;
  end

  `BTMX_ASSERT(a_nf_range, (nf != '0) && (nf <= btmx_pkg::CNT_W'(btmx_pkg::NODE_COUNT)), "allocation pointer out of range")
  `BTMX_ASSERT_NEXT(a_full_keeps_pool, ctl.ins_step && !stat.hit && !stat.pool_ok, nf == $past(nf), "full insert changed the pool")
  `BTMX_ASSERT(a_result_slot_free, !ctl.out_load || stat.out_free, "result overwritten before taken")
  `BTMX_ASSERT_NEXT(a_clear_resets, ctl.clear, (nf == btmx_pkg::CNT_W'(1)) && (root == '0), "clear left trie state")

endmodule

// File: hw/rtl/btmx_ctrl.sv
// Trie controller: sequences insert walk, node allocation, query walk and result hand-off.
`include "bit_trie_max_xor_macros.svh"

module btmx_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  logic [1:0]         func,
  input  btmx_pkg::dp_stat_t stat,
  output btmx_pkg::dp_cmd_t  ctl
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_INS_WALK = 5'b00010,
    S_ALLOC    = 5'b00100,
    S_QUERY    = 5'b01000,
    S_FINISH   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    cmd_ready  = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.load = 1'b1;
          case (func)
            btmx_pkg::FUNC_INSERT: state_next = S_INS_WALK;
            btmx_pkg::FUNC_QUERY:  state_next = S_QUERY;
            btmx_pkg::FUNC_CLEAR: begin
              ctl.clear  = 1'b1;
              state_next = S_FINISH;
            end
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_INS_WALK: begin
        ctl.ins_step = 1'b1;
        if (stat.hit) begin
          if (stat.lvl_zero) begin
            state_next = S_FINISH;
          end
        end else if (stat.pool_ok) begin
          state_next = S_ALLOC;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_ALLOC: begin
        ctl.alloc_step = 1'b1;
        if (stat.lvl_zero) begin
          state_next = S_FINISH;
        end
      end
      S_QUERY: begin
        ctl.qry_step = 1'b1;
        if (stat.q_end) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `BTMX_ASSERT(a_alloc_after_walk, (state != S_ALLOC) || ($past(state) == S_INS_WALK) || ($past(state) == S_ALLOC), "allocation without a walk")
  `BTMX_ASSERT_NEXT(a_result_then_idle, ctl.out_load, state == S_IDLE, "no return to idle after result")

endmodule

// File: hw/rtl/bit_trie_max_xor.sv
// Bit trie max xor: stores 32-bit values in a binary trie and answers maximum-xor
// queries. One transaction at a time: a query accepts the command, walks one trie level
// per cycle over up to 32 levels, stopping at the root on an empty trie, then gives the
// result; an insert accepts, walks the existing path plus the level where it ends (32
// levels at most), allocates the missing nodes one per cycle (32 at most), then gives the
// result; clear and unused codes go from accept straight to the result. The result step
// stalls while the previous result is still waiting to be taken. The pace is set by the
// node memory: each level's read address comes from the previous level's read. A finished
// result waits in an output register, so the next transaction is accepted while it is
// still held. The root node sits in flip-flops, so reset and clear take effect at once
// with no memory clearing pass. Status reports an empty trie on query and a full pool on insert.

module bit_trie_max_xor (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  btmx_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output btmx_pkg::res_t res
);

  btmx_pkg::dp_cmd_t  ctl;
  btmx_pkg::dp_stat_t stat;

  btmx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .func      (cmd.func),
    .stat      (stat),
    .ctl       (ctl)
  );

  btmx_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (cmd),
    .ctl       (ctl),
    .stat      (stat),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

// File: verif/tb_bit_trie_max_xor.sv
// Testbench for bit_trie_max_xor: directed and random trie traffic checked against a predictor.
module tb_bit_trie_max_xor;
  timeunit 1ns;
  timeprecision 1ps;

  // Function code the block treats as a no-op
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1350;
  localparam int DRAIN_CYCLES = 80;

  // Tracks a shadow trie and the answers the block owes
  class trie_tracker;
    int              lchild[btmx_pkg::NODE_COUNT];
    int              rchild[btmx_pkg::NODE_COUNT];
    int              next_node;
    btmx_pkg::res_t  pending_answers[$];
    int              errors;

    function new();
      errors = 0;
      empty_trie();
    endfunction

    function void empty_trie();
      lchild[0] = 0;
      rchild[0] = 0;
      next_node = 1;
    endfunction

    // All-or-nothing insert: count missing nodes first
    function logic [1:0] add_value(logic [31:0] v);
      int node;
      int lvl;
      int c;
      int fresh;
      node = 0;
      lvl  = btmx_pkg::VALUE_BITS - 1;
      while (lvl >= 0) begin
        c = v[lvl] ? rchild[node] : lchild[node];
        if (c == 0) break;
        node = c;
        lvl--;
      end
      if (btmx_pkg::NODE_COUNT - next_node < lvl + 1) return btmx_pkg::STAT_FULL;
      while (lvl >= 0) begin
        fresh = next_node;
        next_node++;
        lchild[fresh] = 0;
        rchild[fresh] = 0;
        if (v[lvl]) rchild[node] = fresh;
        else lchild[node] = fresh;
        node = fresh;
        lvl--;
      end
      return btmx_pkg::STAT_OK;
    endfunction

    // Greedy walk toward the opposite bit
    function logic [1:0] best_partner(logic [31:0] v, output logic [31:0] p);
      int node;
      int want;
      int same;
      p = '0;
      node = 0;
      if (lchild[0] == 0 && rchild[0] == 0) return btmx_pkg::STAT_EMPTY;
      for (int lvl = btmx_pkg::VALUE_BITS - 1; lvl >= 0; lvl--) begin
        want = v[lvl] ? lchild[node] : rchild[node];
        same = v[lvl] ? rchild[node] : lchild[node];
        if (want != 0) begin
          p[lvl] = ~v[lvl];
          node = want;
        end else if (same != 0) begin
          p[lvl] = v[lvl];
          node = same;
        end else begin
          // dead end: remaining bits follow the value
          for (int k = lvl; k >= 0; k--) p[k] = v[k];
          break;
        end
      end
      return btmx_pkg::STAT_OK;
    endfunction

    function void note_command(btmx_pkg::cmd_t c);
      btmx_pkg::res_t ans;
      logic [31:0]    v;
      logic [31:0]    p;
      ans = '0;
      v = c.value & btmx_pkg::VALUE_MASK;
      case (c.func)
        btmx_pkg::FUNC_INSERT: ans.status = add_value(v);
        btmx_pkg::FUNC_QUERY: begin
          ans.status = best_partner(v, p);
          if (ans.status == btmx_pkg::STAT_OK) begin
            ans.partner = p;
            ans.max_xor = p ^ v;
          end
        end
        btmx_pkg::FUNC_CLEAR: empty_trie();
        default: ;
      endcase
      pending_answers.push_back(ans);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_answer(btmx_pkg::res_t r);
      btmx_pkg::res_t ans;
      if (pending_answers.size() == 0) begin
        report_mismatch("result with no transaction pending", r.partner, '0);
      end else begin
        ans = pending_answers.pop_front();
        if (r.status !== ans.status)
          report_mismatch("status", 32'(r.status), 32'(ans.status));
        if (r.max_xor !== ans.max_xor) report_mismatch("max_xor", r.max_xor, ans.max_xor);
        if (r.partner !== ans.partner) report_mismatch("partner", r.partner, ans.partner);
      end
    endtask
  endclass

  logic           clk;
  logic           rst;
  logic           cmd_valid;
  logic           cmd_ready;
  btmx_pkg::cmd_t cmd;
  logic           res_valid;
  logic           res_ready;
  btmx_pkg::res_t res;

  trie_tracker tracker = new();
  logic [31:0] kept_vals[$];
  int          sent;
  bit          calm;

  bit_trie_max_xor u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop for a hung run
  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

  // Result side: check accepted transactions, then pick next ready
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) tracker.check_answer(res);
    res_ready <= calm || ($urandom_range(0, 99) >= 36);
  end

  // Value mix: extremes, small values, neighbors of stored values, full random
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    int          idx;
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      1, 2: v = $urandom_range(0, 255);
      3, 4: begin
        if (kept_vals.size() > 0) begin
          v = kept_vals[$urandom_range(0, kept_vals.size() - 1)];
          if ($urandom_range(0, 1)) begin
            idx = $urandom_range(0, 31);
            v[idx] = ~v[idx];
          end else begin
            v = v ^ $urandom_range(0, 15);
          end
        end else begin
          v = $urandom;
        end
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Command side: optional gap, then hold valid until accepted
  task send_cmd(logic [1:0] func, logic [31:0] value);
    int             gap;
    btmx_pkg::cmd_t c;
    gap = 0;
    while (!calm && $urandom_range(0, 99) < 36) gap++;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    c.func  = func;
    c.value = value;
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    tracker.note_command(c);
    sent++;
    if (func == btmx_pkg::FUNC_CLEAR) kept_vals.delete();
    else if (func == btmx_pkg::FUNC_INSERT && kept_vals.size() < 512) kept_vals.push_back(value);
  endtask

  initial begin
    int n;
    sent = 0;
    calm = 1'b0;
    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    cmd       <= '0;
    res_ready <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty trie, extremes, duplicates, no-op code, clear
    send_cmd(btmx_pkg::FUNC_QUERY, 32'h0000_0000);
    send_cmd(btmx_pkg::FUNC_QUERY, 32'hFFFF_FFFF);
    send_cmd(FUNC_UNUSED, 32'hDEAD_BEEF);
    send_cmd(btmx_pkg::FUNC_CLEAR, 32'h0000_0000);
    send_cmd(btmx_pkg::FUNC_INSERT, 32'h0000_0000);
    send_cmd(btmx_pkg::FUNC_QUERY, 32'h0000_0000);
    send_cmd(btmx_pkg::FUNC_QUERY, 32'hFFFF_FFFF);
    send_cmd(btmx_pkg::FUNC_INSERT, 32'hFFFF_FFFF);
    send_cmd(btmx_pkg::FUNC_QUERY, 32'h0000_0000);
    send_cmd(btmx_pkg::FUNC_QUERY, 32'hFFFF_FFFF);
    send_cmd(btmx_pkg::FUNC_INSERT, 32'hFFFF_FFFF);
    send_cmd(btmx_pkg::FUNC_INSERT, 32'h8000_0000);
    send_cmd(btmx_pkg::FUNC_QUERY, 32'h7FFF_FFFF);
    send_cmd(btmx_pkg::FUNC_INSERT, 32'h0000_0001);
    send_cmd(btmx_pkg::FUNC_QUERY, 32'h0000_0001);
    send_cmd(FUNC_UNUSED, 32'hFFFF_FFFF);
    send_cmd(btmx_pkg::FUNC_CLEAR, 32'hFFFF_FFFF);
    send_cmd(btmx_pkg::FUNC_QUERY, 32'h1234_5678);
    send_cmd(btmx_pkg::FUNC_INSERT, 32'h5555_5555);
    send_cmd(btmx_pkg::FUNC_QUERY, 32'hAAAA_AAAA);
    send_cmd(btmx_pkg::FUNC_QUERY, 32'h5555_5555);
    send_cmd(btmx_pkg::FUNC_CLEAR, 32'h0000_0000);

    // Random: mostly insert-then-query sets, some large enough to fill the pool
    while (sent < RANDOM_ITEMS) begin
      calm = (sent >= 500 && sent < 700);
      if ($urandom_range(0, 9) < 2) begin
        repeat ($urandom_range(3, 10)) send_cmd(2'($urandom_range(0, 3)), $urandom);
      end else begin
        if ($urandom_range(0, 3) != 0) send_cmd(btmx_pkg::FUNC_CLEAR, $urandom);
        n = ($urandom_range(0, 24) == 0) ? $urandom_range(150, 260) : $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
          send_cmd(btmx_pkg::FUNC_INSERT, pick_value());
          if ($urandom_range(0, 3) == 0) send_cmd(btmx_pkg::FUNC_QUERY, pick_value());
        end
        repeat ($urandom_range(2, 8)) send_cmd(btmx_pkg::FUNC_QUERY, pick_value());
      end
    end
    calm = 1'b0;
    cmd_valid <= 1'b0;

    // Drain, then allow for any stray result
    while (tracker.pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.pending_answers.size() != 0)
      tracker.report_mismatch("results missing", 32'(tracker.pending_answers.size()), '0);
    if (tracker.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
